// ===== hdl/pps_pkg.sv =====
// Shared types and constants for the pipelined prime sieve.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package pps_pkg;

   // Fixed width of the candidate and prime fields on the ports
   localparam int CANDIDATE_BITS = 16;
   // Widest value the cells can be built for
   localparam int MAX_VALUE_BITS = 32;

   // Flags that travel with a candidate from cell to cell
   typedef struct packed {
      logic valid;   // slot holds a word
      logic live;    // candidate is two or more
      logic clear;   // empty every cell this word passes
      logic hit;     // some stored prime divides the candidate
      logic stored;  // candidate already kept in a cell
   } tok_flags_type;

   // Control broadcast from the slot sequencer to every cell
   typedef struct packed {
      logic step;     // one remainder bit this cycle
      logic advance;  // hand every word to the next cell
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/pps_ifs.sv =====
// Valid/ready channel interfaces for the prime sieve request and response words.
// Depends on pps_pkg for the field widths.
`default_nettype none

interface pps_req_if;
   logic                                valid;
   logic                                ready;
   logic [pps_pkg::CANDIDATE_BITS-1:0]  candidate;
   logic                                clear;

   modport source (output valid, output candidate, output clear, input ready);
   modport sink   (input valid, input candidate, input clear, output ready);
endinterface

interface pps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pps_pkg::CANDIDATE_BITS-1:0]  prime_value;
   logic                                stored;

   modport source (output valid, output prime_value, output stored, input ready);
   modport sink   (input valid, input prime_value, input stored, output ready);
endinterface

`default_nettype wire

// ===== hdl/pps_cell.sv =====
// One filter cell of the prime sieve chain: holds at most one prime and tests
// the passing word against it with a bit-serial restoring remainder. Uses pps_pkg.
`default_nettype none

module pps_cell #(
   parameter int VALUE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pps_pkg::cell_ctl_type    ctl,
   input  wire pps_pkg::tok_flags_type   flags_in,
   input  wire logic [VALUE_BITS-1:0]    value_in,
   output pps_pkg::tok_flags_type        flags_out,
   output logic [VALUE_BITS-1:0]         value_out
);

   pps_pkg::tok_flags_type  flags_ff;
   logic                    occ_ff, occ_in;
   logic [VALUE_BITS-1:0]   value_ff;
   logic [VALUE_BITS-1:0]   div_ff;
   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [VALUE_BITS-1:0]   prime_ff;

   logic [VALUE_BITS:0]     trial;
   logic [VALUE_BITS:0]     prime_ext;
   logic [VALUE_BITS:0]     diff;
   logic                    occ_eff;
   logic                    active;
   logic                    divides;
   logic                    store_here;

   always_comb begin
      trial     = {rem_ff, div_ff[VALUE_BITS-1]};
      prime_ext = {1'b0, prime_ff};
      diff      = trial - prime_ext;
      if (trial >= prime_ext) begin
         rem_in = diff[VALUE_BITS-1:0];
      end else begin
         rem_in = trial[VALUE_BITS-1:0];
      end

      // a clear riding on this word empties the cell before the word is tested
      occ_eff    = occ_ff & ~flags_ff.clear;
      active     = flags_ff.valid & flags_ff.live & ~flags_ff.hit & ~flags_ff.stored;
      divides    = active & occ_eff & (rem_ff == '0);
      store_here = active & ~occ_eff;

      flags_out        = flags_ff;
      flags_out.hit    = flags_ff.hit | divides;
      flags_out.stored = flags_ff.stored | store_here;
      value_out        = value_ff;

      occ_in = occ_ff;
      if (flags_ff.valid) begin
         occ_in = occ_eff | store_here;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         occ_ff   <= 1'b0;
      end else if (ctl.advance) begin
         flags_ff <= flags_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         value_ff <= value_in;
         div_ff   <= value_in;
         rem_ff   <= '0;
         if (store_here) begin
            prime_ff <= value_ff;
         end
      end else if (ctl.step) begin
         div_ff <= {div_ff[VALUE_BITS-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pipelined_prime_sieve_top.sv =====
// Top level of the pipelined prime sieve: slot sequencer, cell chain, response register.
// Depends on pps_pkg, pps_ifs (pps_req_if, pps_rsp_if) and pps_cell.
`default_nettype none

// Prime sieve built as a chain of NUM_STAGES filter cells. Every word moves one cell per
// slot: a bit-serial remainder in each cell, then a shift of the whole chain. The block
// takes one request word per slot, set by the remainder loop in the cells, unless the
// output stalls, and a word passes every cell in turn before its response is registered.
// A candidate that a stored prime divides, or one below two, gives no response. A survivor
// is kept in the first empty cell it reaches and leaves with stored set, or with stored
// clear when every cell is taken. A request with clear set empties each cell as it passes,
// so later words see an empty chain but for that word's own candidate if it is two or more.
// A response waiting on the output stalls the chain at the slot end if the leaving word has one too.
module pipelined_prime_sieve_top #(
   parameter int NUM_STAGES = 64,
   parameter int VALUE_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   pps_req_if.sink    req_chan,
   pps_rsp_if.source  rsp_chan
);

   localparam int                  CNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam logic [CNT_BITS-1:0] SLOT_LAST = CNT_BITS'(VALUE_BITS);

   logic [CNT_BITS-1:0]                      cnt_ff, cnt_in;
   logic                                     slot_done;
   logic                                     emit;
   logic                                     advance;
   pps_pkg::cell_ctl_type                    ctl;

   pps_pkg::tok_flags_type                   chain_flags [NUM_STAGES+1];
   logic [VALUE_BITS-1:0]                    chain_value [NUM_STAGES+1];
   logic [VALUE_BITS-1:0]                    req_value;
   logic [pps_pkg::MAX_VALUE_BITS-1:0]       last_wide;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [pps_pkg::CANDIDATE_BITS-1:0]       rsp_value_ff;
   logic                                     rsp_stored_ff;

   // feed the head of the chain straight from the request channel
   assign req_value             = VALUE_BITS'(req_chan.candidate);
   assign chain_flags[0].valid  = req_chan.valid;
   assign chain_flags[0].live   = |req_value[VALUE_BITS-1:1];
   assign chain_flags[0].clear  = req_chan.clear;
   assign chain_flags[0].hit    = 1'b0;
   assign chain_flags[0].stored = 1'b0;
   assign chain_value[0]        = req_value;

   always_comb begin
      slot_done = (cnt_ff == SLOT_LAST);
      emit      = chain_flags[NUM_STAGES].valid & chain_flags[NUM_STAGES].live
                  & ~chain_flags[NUM_STAGES].hit;
      // hold the slot end while the response register is still full and the leaving word needs it
      advance   = slot_done & (~emit | ~rsp_valid_ff | rsp_chan.ready);

      ctl.step    = ~slot_done;
      ctl.advance = advance;

      cnt_in = cnt_ff;
      if (advance) begin
         cnt_in = '0;
      end else if (!slot_done) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      last_wide = pps_pkg::MAX_VALUE_BITS'(chain_value[NUM_STAGES]);

      req_chan.ready       = advance;
      rsp_chan.valid       = rsp_valid_ff;
      rsp_chan.prime_value = rsp_value_ff;
      rsp_chan.stored      = rsp_stored_ff;
   end

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
      pps_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .flags_in  (chain_flags[i]),
         .value_in  (chain_value[i]),
         .flags_out (chain_flags[i+1]),
         .value_out (chain_value[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_ff  <= last_wide[pps_pkg::CANDIDATE_BITS-1:0];
         rsp_stored_ff <= chain_flags[NUM_STAGES].stored;
      end
   end

endmodule

`default_nettype wire
